### rtl/mfbd_pkg.sv
// ----------------------------------------------------------------------------
// mfbd_pkg: shared types and constants of the meter frame BCD decoder
// Frame delimiters, result status codes, the captured frame record, the
// result record and the digit bit-reversal helpers.
// ----------------------------------------------------------------------------
package mfbd_pkg;

	localparam logic [7:0] FRAME_START = 8'h02;
	localparam logic [7:0] FRAME_END   = 8'h03;

	// Digit value limit: a reversed digit above this is not decimal.
	localparam logic [3:0] DIGIT_MAX = 4'd9;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_END   = 2'd1,
		STATUS_BAD_DIGIT = 2'd2
	} status_t;

	// Frame handed from the tracker to the decoder.
	typedef struct packed {
		logic        end_ok;
		logic [15:0] word;
	} frame_t;

	// One decoded result, packed in tdata order (lowest field last here).
	typedef struct packed {
		logic [1:0]  decimal_places;
		logic [10:0] magnitude;
		logic        is_positive;
		status_t     status;
	} result_t;

	function automatic logic [3:0] rev4(input logic [3:0] v);
		rev4 = {v[0], v[1], v[2], v[3]};
	endfunction

	function automatic logic [1:0] rev2(input logic [1:0] v);
		rev2 = {v[0], v[1]};
	endfunction

endpackage

### rtl/mfbd_frame_tracker.sv
// ----------------------------------------------------------------------------
// mfbd_frame_tracker: byte position tracking and frame capture
// Hunts for the start byte, collects the two data bytes and registers a
// completed frame, with its end byte check, into the first pipeline stage.
// ----------------------------------------------------------------------------
module mfbd_frame_tracker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_accept,
	input  logic [7:0]      rx_byte,
	input  logic            advance,
	output logic            frame_valid_s1,
	output mfbd_pkg::frame_t frame_s1
);
	import mfbd_pkg::*;

	localparam logic [2:0] POS_HUNT = 3'd0;
	localparam logic [2:0] POS_SKIP = 3'd1;
	localparam logic [2:0] POS_LOW  = 3'd2;
	localparam logic [2:0] POS_HIGH = 3'd3;
	localparam logic [2:0] POS_END  = 3'd4;

	logic [2:0] pos_q;
	logic [2:0] pos_next;
	logic [7:0] low_q;
	logic [7:0] high_q;
	logic       load_s1;

	// The first stage may load when it is empty or when its frame moves on.
	assign load_s1 = advance || !frame_valid_s1;

	always_comb begin
		unique case (pos_q)
			POS_HUNT: pos_next = (rx_byte == FRAME_START) ? POS_SKIP : POS_HUNT;
			POS_SKIP: pos_next = POS_LOW;
			POS_LOW:  pos_next = POS_HIGH;
			POS_HIGH: pos_next = POS_END;
			default:  pos_next = POS_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= POS_HUNT;
			low_q          <= 8'd0;
			high_q         <= 8'd0;
			frame_valid_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				pos_q <= pos_next;
				if (pos_q == POS_LOW) begin
					low_q <= rx_byte;
				end
				if (pos_q == POS_HIGH) begin
					high_q <= rx_byte;
				end
			end
			if (load_s1) begin
				frame_valid_s1 <= in_accept && (pos_q == POS_END);
			end
		end
	end

	// Frame payload needs no reset; it is qualified by frame_valid_s1.
	always_ff @(posedge clk) begin
		if (load_s1 && in_accept && (pos_q == POS_END)) begin
			frame_s1.end_ok <= (rx_byte == FRAME_END);
			frame_s1.word   <= {high_q, low_q};
		end
	end

endmodule

### rtl/mfbd_word_decoder.sv
// ----------------------------------------------------------------------------
// mfbd_word_decoder: decode of one captured frame word
// Reverses the digit and decimal place fields, checks the digits and forms
// the binary magnitude and the status of the result.
// ----------------------------------------------------------------------------
module mfbd_word_decoder (
	input  mfbd_pkg::frame_t  frame,
	output mfbd_pkg::result_t result
);
	import mfbd_pkg::*;

	logic [3:0]  d1;
	logic [3:0]  d2;
	logic [3:0]  d3;
	logic        digit_bad;
	logic [10:0] mag;

	assign d1 = rev4(frame.word[5:2]);
	assign d2 = rev4(frame.word[9:6]);
	assign d3 = rev4(frame.word[13:10]);

	assign digit_bad = (d1 > DIGIT_MAX) || (d2 > DIGIT_MAX) || (d3 > DIGIT_MAX);

	// Largest value is 1999, so the sum fits in 11 bits.
	assign mag = ({10'd0, frame.word[1]} * 11'd1000)
	           + ({7'd0, d1} * 11'd100)
	           + ({7'd0, d2} * 11'd10)
	           + {7'd0, d3};

	always_comb begin
		result = '0;
		if (!frame.end_ok) begin
			result.status = STATUS_BAD_END;
		end else if (digit_bad) begin
			result.status = STATUS_BAD_DIGIT;
		end else begin
			result.status         = STATUS_OK;
			result.is_positive    = frame.word[0];
			result.magnitude      = mag;
			result.decimal_places = rev2(frame.word[15:14]);
		end
	end

endmodule

### rtl/meter_frame_bcd_decoder_top.sv
// ----------------------------------------------------------------------------
// meter_frame_bcd_decoder_top: meter frame assembler and BCD value decoder
// Collects five-byte meter frames from a byte stream and emits one decoded
// measurement for every completed frame.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata) takes one received serial
// byte per transaction. Bytes other than the start byte are dropped while
// the block hunts for a frame; inside a frame every byte counts as content.
// The master channel (m_tvalid, m_tready, m_tdata) carries one result
// transaction for each fifth frame byte, good or bad; no other byte gives a
// result. A frame with a wrong end byte reports a framing error, a digit
// above nine reports a digit error, and both return zeros in the value
// fields.
// Throughput is one byte per cycle while s_tready is high, set by the single byte position tracker.
// The completed frame is registered in the first stage, decoded
// combinationally from that stage and held in the output register.
// When the receiver stalls, the output register holds its result; the
// first stage keeps taking bytes that give no result until a second frame
// completes, and then s_tready drops until the output drains.
// Reset clears the byte position to hunting, the data bytes to zero and
// empties both stages.
// ----------------------------------------------------------------------------
module meter_frame_bcd_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [1:0] status, [2] is_positive,
	                               // [13:3] magnitude, [15:14] decimal_places
);
	import mfbd_pkg::*;

	logic    in_accept;
	logic    advance;
	logic    frame_valid_s1;
	frame_t  frame_s1;
	result_t result;
	logic    m_tvalid_q;
	result_t m_result_q;

	// The pipeline moves whenever the output register is empty or drains.
	assign advance   = !m_tvalid_q || m_tready;
	assign s_tready  = !frame_valid_s1 || advance;
	assign in_accept = s_tvalid && s_tready;

	mfbd_frame_tracker u_tracker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_accept      (in_accept),
		.rx_byte        (s_tdata),
		.advance        (advance),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1)
	);

	mfbd_word_decoder u_decoder (
		.frame  (frame_s1),
		.result (result)
	);

	// Output register: loads the decoded first stage whenever it advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= frame_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_valid_s1) begin
			m_result_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_result_q;

endmodule
